// File: rtl/nqc_pkg.sv
package nqc_pkg;

    localparam int MAX_HALF_WINDOW = 8;
    localparam int POSITION_BITS   = 16;

    localparam int Q_W        = 8;
    localparam int HALF_REG_W = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam int WIN_DEPTH = 2 * MAX_HALF_WINDOW + 1;
    localparam int H_W       = $clog2(MAX_HALF_WINDOW + 1);
    localparam int OFF_W     = $clog2(WIN_DEPTH);
    localparam int CMP_W     = (H_W > HALF_REG_W) ? H_W : HALF_REG_W;

    localparam int RESULT_BITS = POSITION_BITS + 1 + Q_W + 1;
    localparam int TDATA_W     = ((RESULT_BITS + 7) / 8) * 8;

    localparam logic [Q_W-1:0]        Q_MAX              = '1;
    localparam logic [CFG_DATA_W-1:0] PRIMARY_RESET      = 8'd20;
    localparam logic [CFG_DATA_W-1:0] SECONDARY_RESET    = 8'd15;
    localparam logic [HALF_REG_W-1:0] WINDOW_HALF_RESET  = 4'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRIMARY     = 2'd0,
        REG_SECONDARY   = 2'd1,
        REG_WINDOW_HALF = 2'd2
    } t_reg_idx;

    typedef logic [CMP_W-1:0] t_cmp;

    typedef struct packed {
        logic                     has_neighbor;
        logic [Q_W-1:0]           lowest_neighbor;
        logic                     pass;
        logic [POSITION_BITS-1:0] position;
        logic                     last_result;
    } t_result;

endpackage

// File: rtl/neighborhood_quality_check_unit.sv
// a result is scored from the registered window once the request completing its
// window (h later bases, or the read's last base) is accepted, then registered in
// the output buffer on o_m; throughput while it has room: one base per cycle
// within a read; the read's last base releases up to h+1 results, one per cycle,
// and input waits for them; synchronous active-low reset clears the counters and
// output buffer and restores register defaults; the quality window is not cleared
module neighborhood_quality_check_unit
    import nqc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [Q_W-1:0]        i_s_tdata,   // [7:0] quality
    input  logic                  i_s_tlast,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [TDATA_W-1:0]    o_m_tdata,   // position, pass, lowest_neighbor, has_neighbor
    output logic                  o_m_tlast,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [CFG_DATA_W-1:0]    r_primary;
    logic [CFG_DATA_W-1:0]    r_secondary;
    logic [HALF_REG_W-1:0]    r_window_half;
    logic [Q_W-1:0]           r_win [WIN_DEPTH];
    logic [POSITION_BITS-1:0] r_recv;
    logic [POSITION_BITS-1:0] r_next;
    logic                     r_flush;
    logic [H_W-1:0]           r_h_step;
    logic [POSITION_BITS-1:0] n_recv;
    logic [POSITION_BITS-1:0] n_next;
    logic                     n_flush;
    logic [H_W-1:0]           n_h_step;

    logic [H_W-1:0]           eff_h;
    logic [POSITION_BITS-1:0] pending;
    logic [H_W-1:0]           center_off;
    logic [H_W-1:0]           lead;
    logic [H_W-1:0]           trail;
    logic                     need;
    logic                     last_emit;
    logic                     final_emit;
    logic                     buf_ready;
    logic                     do_emit;
    logic                     s_accept;
    t_result                  score;
    t_result                  out_res;

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primary     <= PRIMARY_RESET;
            r_secondary   <= SECONDARY_RESET;
            r_window_half <= WINDOW_HALF_RESET;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_PRIMARY:     r_primary     <= i_cfg_data;
                REG_SECONDARY:   r_secondary   <= i_cfg_data;
                REG_WINDOW_HALF: r_window_half <= i_cfg_data[HALF_REG_W-1:0];
                default: ;
            endcase
        end
    end

    assign eff_h = (t_cmp'(r_window_half) > t_cmp'(MAX_HALF_WINDOW))
                   ? H_W'(MAX_HALF_WINDOW) : H_W'(r_window_half);

    // emit control, h is the value taken with the latest request
    assign pending    = r_recv - r_next;
    assign need       = (pending != '0) && (r_flush || pending > POSITION_BITS'(r_h_step));
    assign last_emit  = r_flush ? (pending == POSITION_BITS'(1))
                                : (pending == POSITION_BITS'(r_h_step) + POSITION_BITS'(1));
    assign final_emit = r_flush && (pending == POSITION_BITS'(1));
    assign do_emit    = need && buf_ready;
    assign o_s_tready = !need || (buf_ready && last_emit);
    assign s_accept   = i_s_tvalid && o_s_tready;

    assign center_off = H_W'(pending - POSITION_BITS'(1));
    assign trail      = (center_off < r_h_step) ? center_off : r_h_step;
    assign lead       = (r_next < POSITION_BITS'(r_h_step)) ? H_W'(r_next) : r_h_step;

    always_comb begin
        n_recv   = r_recv;
        n_next   = r_next;
        n_flush  = r_flush;
        n_h_step = r_h_step;
        if (do_emit) begin
            if (final_emit) begin
                n_recv  = '0;
                n_next  = '0;
                n_flush = 1'b0;
            end else begin
                n_next = r_next + POSITION_BITS'(1);
            end
        end
        if (s_accept) begin
            n_recv   = n_recv + POSITION_BITS'(1);
            n_flush  = i_s_tlast;
            n_h_step = eff_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recv   <= '0;
            r_next   <= '0;
            r_flush  <= 1'b0;
            r_h_step <= '0;
        end else begin
            r_recv   <= n_recv;
            r_next   <= n_next;
            r_flush  <= n_flush;
            r_h_step <= n_h_step;
        end
    end

    // tap 0 holds the newest base
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_win[0] <= i_s_tdata;
            for (int j = 1; j < WIN_DEPTH; j++) begin
                r_win[j] <= r_win[j-1];
            end
        end
    end

    nqc_score u_score (
        .i_win        (r_win),
        .i_center_off (center_off),
        .i_lead       (lead),
        .i_trail      (trail),
        .i_position   (r_next),
        .i_final      (final_emit),
        .i_primary    (r_primary),
        .i_secondary  (r_secondary),
        .o_result     (score)
    );

    nqc_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (need),
        .i_result (score),
        .o_ready  (buf_ready),
        .o_valid  (o_m_tvalid),
        .o_result (out_res),
        .i_ready  (i_m_tready)
    );

    assign o_m_tdata = TDATA_W'({out_res.has_neighbor, out_res.lowest_neighbor,
                                 out_res.pass, out_res.position});
    assign o_m_tlast = out_res.last_result;

`ifndef SYNTH
    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pending <= POSITION_BITS'(MAX_HALF_WINDOW + 1))
        else $error("pending positions exceed the window");

    a_flush_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush |-> pending != '0)
        else $error("flush active with nothing pending");

    a_final_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_emit && final_emit) |=> (r_next == '0 && !(r_flush && pending == '0)))
        else $error("read counters not cleared after final result");
`endif

endmodule

// File: rtl/nqc_score.sv
module nqc_score
    import nqc_pkg::*;
(
    input  logic [Q_W-1:0]           i_win [WIN_DEPTH],
    input  logic [H_W-1:0]           i_center_off,
    input  logic [H_W-1:0]           i_lead,
    input  logic [H_W-1:0]           i_trail,
    input  logic [POSITION_BITS-1:0] i_position,
    input  logic                     i_final,
    input  logic [CFG_DATA_W-1:0]    i_primary,
    input  logic [CFG_DATA_W-1:0]    i_secondary,
    output t_result                  o_result
);

    localparam int TREE_N = 1 << $clog2(WIN_DEPTH);

    logic [OFF_W:0]   center_ext;
    logic [OFF_W:0]   lo_off;
    logic [OFF_W:0]   hi_off;
    logic [Q_W-1:0]   node [2*TREE_N-1];
    logic [Q_W-1:0]   center_q;
    logic [Q_W-1:0]   lowest;
    logic             has;

    assign center_ext = (OFF_W+1)'(i_center_off);
    assign lo_off     = center_ext - (OFF_W+1)'(i_trail);
    assign hi_off     = center_ext + (OFF_W+1)'(i_lead);

    // leaves: taps inside the clipped window, center left out
    for (genvar j = 0; j < TREE_N; j++) begin : g_leaf
        if (j < WIN_DEPTH) begin : g_tap
            localparam logic [OFF_W:0] J = (OFF_W+1)'(j);
            assign node[TREE_N-1+j] = (J != center_ext && J >= lo_off && J <= hi_off)
                                      ? i_win[j] : Q_MAX;
        end else begin : g_pad
            assign node[TREE_N-1+j] = Q_MAX;
        end
    end

    for (genvar i = 0; i < TREE_N - 1; i++) begin : g_node
        assign node[i] = (node[2*i+1] < node[2*i+2]) ? node[2*i+1] : node[2*i+2];
    end

    assign lowest   = node[0];
    assign center_q = i_win[OFF_W'(i_center_off)];
    assign has      = (i_lead != '0) || (i_trail != '0);

    always_comb begin
        o_result.position        = i_position;
        o_result.lowest_neighbor = lowest;
        o_result.has_neighbor    = has;
        o_result.last_result     = i_final;
        o_result.pass            = (center_q > i_primary) && (!has || lowest > i_secondary);
    end

endmodule

// File: rtl/nqc_out_buf.sv
module nqc_out_buf
    import nqc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_result,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_result,
    input  logic    i_ready
);

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    n_main_valid;
    logic    n_skid_valid;
    logic    load;

    assign o_ready  = !r_skid_valid;
    assign o_valid  = r_main_valid;
    assign o_result = r_main;
    assign load     = i_valid && !r_skid_valid;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        if (r_skid_valid) begin
            if (i_ready) begin
                n_skid_valid = 1'b0;
            end
        end else if (load) begin
            if (r_main_valid && !i_ready) begin
                n_skid_valid = 1'b1;
            end else begin
                n_main_valid = 1'b1;
            end
        end else if (i_ready) begin
            n_main_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (i_ready) begin
                r_main <= r_skid;
            end
        end else if (load) begin
            if (r_main_valid && !i_ready) begin
                r_skid <= i_result;
            end else begin
                r_main <= i_result;
            end
        end
    end

endmodule
